// ===== design/srmq_pkg.sv =====
// Package: constants and types for the sorted range mode query block.
`default_nettype none
package srmq_pkg;
   localparam int MaxLen = 4096;
   localparam int PosW = 13;
   localparam int IdxW = 12;
   localparam int TreeW = 13;
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_QUERY = 1'b1;
   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_ERR = 1'b1;
   typedef logic [PosW-1:0] pos_type;
endpackage
`default_nettype wire

// ===== design/sorted_range_mode_query.sv =====
// Top level: range mode query engine over a loaded non-decreasing array.
// Commands are taken when start is high and busy is low; the block then stays busy until
// done, one item at a time. A load whose value differs from the open run closes that run
// first: for each position of the run it writes the bounds and then one tree path of 12
// levels, a read and a write per level through the single tree port, and then counts the
// new value. A final load closes the open run the same way, if anything is left to close.
// A query with an invalid range ends with an error status and a zero frequency; when both
// ends hold the same value the answer is the range length. Otherwise it walks the tree
// bottom-up, climbing level by level and reading nodes. The result is on the rsp_ ports
// for one cycle with rsp_valid, in the last busy cycle; the receiver cannot stall it.
`default_nettype none
module sorted_range_mode_query import srmq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_cmd,
   input  wire logic [31:0] req_value,
   input  wire logic        req_final_load,
   input  wire logic [12:0] req_range_first,
   input  wire logic [12:0] req_range_last,
   output logic             rsp_valid,
   output logic [12:0]      rsp_frequency,
   output logic             rsp_status
);
   localparam logic [3:0] S_IDLE = 4'd0, S_CLOSE = 4'd1, S_CL_UP = 4'd2, S_CL_RD = 4'd3,
      S_CL_WR = 4'd4, S_Q_RD = 4'd5, S_Q_CHK = 4'd6, S_Q_RUN = 4'd7, S_T_STEP = 4'd8,
      S_T_RD = 4'd9, S_T_ACC = 4'd10, S_DONE = 4'd11, S_LOADFIN = 4'd12;

   logic [31:0]    value_mem [MaxLen];
   logic [2*PosW-1:0] run_mem [MaxLen];
   logic [TreeW-1:0]  tree_mem [2*MaxLen];

   logic [3:0]   state_ff, state_in;
   pos_type      loaded_ff, loaded_in, orb_ff, orb_in;
   logic [31:0]  orv_ff, orv_in;
   logic         fin_ff, fin_in, inc_ff, inc_in;
   pos_type      p_ff, p_in, s_ff, s_in, e_ff, e_in;
   logic [IdxW:0] n_ff, n_in;
   logic [IdxW+1:0] l_ff, l_in, r_ff, r_in;
   pos_type      a_ff, a_in, best_ff, best_in;
   logic         rv_ff, rv_in, rst_ff, rst_in;
   pos_type      rf_ff, rf_in;
   logic [TreeW-1:0] leafv_ff, leafv_in;
   pos_type      lc, sb, se, eb, ee, ns, ne, ca;

   // memory ports
   logic         vwe, rwe, twe;
   logic [IdxW-1:0] vaddr, raddr;
   logic [IdxW:0] taddr;
   logic [31:0]  vwd, vrd_ff;
   logic [2*PosW-1:0] rwd, rrd_ff;
   logic [TreeW-1:0] twd, trd_ff;
   logic [31:0]  vs_ff, vs_in;
   logic [2*PosW-1:0] rs_ff, rs_in;

   always_ff @(posedge clock) begin
      if (vwe) value_mem[vaddr] <= vwd;
      vrd_ff <= value_mem[vaddr];
      if (rwe) run_mem[raddr] <= rwd;
      rrd_ff <= run_mem[raddr];
      if (twe) tree_mem[taddr] <= twd;
      trd_ff <= tree_mem[taddr];
   end

   pos_type rlen;
   assign rlen = pos_type'(loaded_ff - orb_ff + 1'b1);

   always_comb begin
      state_in = state_ff; loaded_in = loaded_ff; orb_in = orb_ff; orv_in = orv_ff;
      fin_in = fin_ff; inc_in = inc_ff; p_in = p_ff; s_in = s_ff; e_in = e_ff; n_in = n_ff;
      l_in = l_ff; r_in = r_ff; a_in = a_ff; best_in = best_ff;
      rv_in = 1'b0; rst_in = rst_ff; rf_in = rf_ff; leafv_in = leafv_ff;
      vs_in = vs_ff; rs_in = rs_ff;
      vwe = 1'b0; rwe = 1'b0; twe = 1'b0;
      vaddr = '0; raddr = '0; taddr = '0; vwd = req_value; rwd = '0; twd = '0;
      lc = loaded_ff; ns = s_ff; ne = e_ff; ca = '0;
      sb = rs_ff[2*PosW-1:PosW]; se = rs_ff[PosW-1:0];
      eb = rrd_ff[2*PosW-1:PosW]; ee = rrd_ff[PosW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_LOAD) begin
                  fin_in = req_final_load;
                  inc_in = 1'b0;
                  state_in = S_LOADFIN;
                  if (loaded_ff != '0 && orb_ff > loaded_ff) begin
                     lc = '0; orb_in = pos_type'(1);
                  end
                  loaded_in = lc;
                  if (lc < pos_type'(MaxLen)) begin
                     vwe = 1'b1; vaddr = lc[IdxW-1:0];
                     loaded_in = lc + 1'b1;
                     if (lc == '0) begin
                        orb_in = pos_type'(1); orv_in = req_value;
                     end else if (req_value != orv_ff) begin
                        // close with the old count, count the new item afterwards
                        orv_in = req_value; loaded_in = lc; inc_in = 1'b1;
                        p_in = orb_ff; state_in = S_CLOSE;
                     end
                  end
               end else begin
                  s_in = req_range_first; e_in = req_range_last;
                  state_in = S_Q_RD;
               end
            end
         end
         S_CLOSE: begin
            // write bounds for position p, set leaf
            if (orb_ff == '0 || orb_ff > loaded_ff) state_in = S_LOADFIN;
            else begin
               rwe = 1'b1; raddr = IdxW'(p_ff - 1'b1); rwd = {orb_ff, loaded_ff};
               twe = 1'b1; taddr = (IdxW+1)'(MaxLen) + (IdxW+1)'(p_ff - 1'b1);
               twd = rlen; leafv_in = rlen;
               n_in = taddr;
               state_in = S_CL_RD;
            end
         end
         S_CL_RD: begin
            taddr = n_ff ^ 1'b1;
            state_in = S_CL_UP;
         end
         S_CL_UP: begin
            // trd_ff = sibling; parent = max
            twe = 1'b1; taddr = n_ff >> 1;
            twd = (trd_ff > leafv_ff) ? trd_ff : leafv_ff;
            leafv_in = twd; n_in = n_ff >> 1;
            if (n_ff[IdxW:1] == IdxW'(1)) state_in = S_CL_WR;
            else state_in = S_CL_RD;
         end
         S_CL_WR: begin
            if (p_ff == loaded_ff) begin
               orb_in = loaded_ff + 1'b1;
               state_in = S_LOADFIN;
            end else begin
               p_in = p_ff + 1'b1; state_in = S_CLOSE;
            end
         end
         S_LOADFIN: begin
            if (inc_ff) begin
               loaded_in = loaded_ff + 1'b1; inc_in = 1'b0;
            end else if (fin_ff) begin
               fin_in = 1'b0; p_in = orb_ff; state_in = S_CLOSE;
            end else state_in = S_DONE;
         end
         S_Q_RD: begin
            if (s_ff == '0 || s_ff > e_ff || e_ff > pos_type'(orb_ff - 1'b1)) begin
               rv_in = 1'b1; rst_in = STATUS_ERR; rf_in = '0; state_in = S_DONE;
            end else begin
               vaddr = IdxW'(s_ff - 1'b1); raddr = IdxW'(s_ff - 1'b1);
               state_in = S_Q_CHK;
            end
         end
         S_Q_CHK: begin
            vs_in = vrd_ff; rs_in = rrd_ff;
            vaddr = IdxW'(e_ff - 1'b1); raddr = IdxW'(e_ff - 1'b1);
            state_in = S_Q_RUN;
         end
         S_Q_RUN: begin
            a_in = '0;
            rst_in = STATUS_OK;
            if (vs_ff == vrd_ff) begin
               rv_in = 1'b1; rf_in = pos_type'(e_ff - s_ff + 1'b1); state_in = S_DONE;
            end else begin
               if (sb < s_ff) begin a_in = pos_type'(se - s_ff + 1'b1); ns = se + 1'b1; end
               if (ee > e_ff) begin ca = pos_type'(e_ff - eb + 1'b1); ne = eb - 1'b1; end
               best_in = ca;
               if (ns != '0 && ns <= ne) begin
                  l_in = (IdxW+2)'(ns - 1'b1) + (IdxW+2)'(MaxLen);
                  r_in = (IdxW+2)'(ne) + (IdxW+2)'(MaxLen);
                  state_in = S_T_STEP;
               end else state_in = S_T_ACC;
            end
         end
         S_T_STEP: begin
            if (l_ff >= r_ff) begin
               state_in = S_T_ACC;
            end else if (l_ff[0]) begin
               taddr = l_ff[IdxW:0]; l_in = l_ff + 1'b1; state_in = S_T_RD;
            end else if (r_ff[0]) begin
               taddr = (IdxW+1)'(r_ff - 1'b1); r_in = r_ff - 1'b1; state_in = S_T_RD;
            end else begin
               l_in = l_ff >> 1; r_in = r_ff >> 1;
            end
         end
         S_T_RD: begin
            if (trd_ff > best_ff) best_in = trd_ff;
            state_in = S_T_STEP;
         end
         S_T_ACC: begin
            rv_in = 1'b1; rst_in = STATUS_OK;
            rf_in = (a_ff > best_ff) ? a_ff : best_ff;
            state_in = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; loaded_ff <= '0; orb_ff <= pos_type'(1); orv_ff <= '0;
         rv_ff <= 1'b0; fin_ff <= 1'b0; inc_ff <= 1'b0;
      end else begin
         state_ff <= state_in; loaded_ff <= loaded_in; orb_ff <= orb_in; orv_ff <= orv_in;
         rv_ff <= rv_in; fin_ff <= fin_in; inc_ff <= inc_in;
      end
      p_ff <= p_in; s_ff <= s_in; e_ff <= e_in; n_ff <= n_in; l_ff <= l_in; r_ff <= r_in;
      a_ff <= a_in; best_ff <= best_in; rst_ff <= rst_in;
      rf_ff <= rf_in; leafv_ff <= leafv_in; vs_ff <= vs_in; rs_ff <= rs_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_frequency = rf_ff;
   assign rsp_status = rst_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rst_ff == STATUS_ERR |-> rf_ff == '0) else $error("err freq");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> busy) else $error("rsp idle");
   a_orb: assert property (@(posedge clock) disable iff (reset)
      orb_ff <= loaded_ff + 1'b1 || orb_ff == pos_type'(1)) else $error("orb");
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for sorted_range_mode_query: directed table plus random arrays, checked by a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top import srmq_pkg::*; ();

   localparam int IdleLimit = 50000;
   localparam int FillLen = 300;

   typedef struct {
      logic        cmd;
      logic [31:0] value;
      logic        fin;
      logic [12:0] first;
      logic [12:0] last;
      bit          typed;
      logic [12:0] freq;
      logic        status;
   } stim_row_type;

   typedef struct {
      logic [12:0] freq;
      logic        status;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_cmd;
   logic [31:0] req_value;
   logic        req_final_load;
   logic [12:0] req_range_first;
   logic [12:0] req_range_last;
   logic        rsp_valid;
   logic [12:0] rsp_frequency;
   logic        rsp_status;

   // typed-in expectation riding along with the item
   logic        row_typed;
   logic [12:0] row_freq;
   logic        row_status;

   answer_type  pending_answers[$];
   int          fail_count;
   int          idle_cycles;
   int          burst_left;

   // predictor state
   logic [31:0] arr_value[MaxLen];
   int          arr_run_lo[MaxLen];
   int          arr_run_hi[MaxLen];
   int          run_tree[2*MaxLen];
   int          arr_len;
   int          run_open_lo;
   logic [31:0] run_open_value;

   stim_row_type dir_rows[25] = '{
      '{CMD_QUERY, 32'h0, 1'b0, 13'd1, 13'd1, 1'b1, 13'd0, STATUS_ERR},
      '{CMD_LOAD, 32'h8000_0000, 1'b0, 13'd0, 13'd0, 1'b0, 13'd0, STATUS_OK},
      '{CMD_LOAD, 32'h8000_0000, 1'b0, 13'd0, 13'd0, 1'b0, 13'd0, STATUS_OK},
      '{CMD_LOAD, 32'h8000_0000, 1'b0, 13'd0, 13'd0, 1'b0, 13'd0, STATUS_OK},
      '{CMD_LOAD, 32'hFFFF_FFFF, 1'b0, 13'd0, 13'd0, 1'b0, 13'd0, STATUS_OK},
      '{CMD_LOAD, 32'h0, 1'b0, 13'd0, 13'd0, 1'b0, 13'd0, STATUS_OK},
      '{CMD_LOAD, 32'h7FFF_FFFF, 1'b0, 13'd0, 13'd0, 1'b0, 13'd0, STATUS_OK},
      '{CMD_LOAD, 32'h7FFF_FFFF, 1'b1, 13'd0, 13'd0, 1'b0, 13'd0, STATUS_OK},
      '{CMD_QUERY, 32'h0, 1'b0, 13'd1, 13'd7, 1'b1, 13'd3, STATUS_OK},
      '{CMD_QUERY, 32'h0, 1'b0, 13'd1, 13'd3, 1'b1, 13'd3, STATUS_OK},
      '{CMD_QUERY, 32'h0, 1'b0, 13'd3, 13'd5, 1'b0, 13'd0, STATUS_OK},
      '{CMD_QUERY, 32'h0, 1'b0, 13'd4, 13'd7, 1'b0, 13'd0, STATUS_OK},
      '{CMD_QUERY, 32'h0, 1'b0, 13'd2, 13'd6, 1'b0, 13'd0, STATUS_OK},
      '{CMD_QUERY, 32'h0, 1'b0, 13'd0, 13'd3, 1'b1, 13'd0, STATUS_ERR},
      '{CMD_QUERY, 32'h0, 1'b0, 13'd5, 13'd4, 1'b1, 13'd0, STATUS_ERR},
      '{CMD_QUERY, 32'h0, 1'b0, 13'd1, 13'd8, 1'b1, 13'd0, STATUS_ERR},
      '{CMD_QUERY, 32'h0, 1'b0, 13'd8191, 13'd8191, 1'b1, 13'd0, STATUS_ERR},
      '{CMD_LOAD, 32'd5, 1'b0, 13'd0, 13'd0, 1'b0, 13'd0, STATUS_OK},
      '{CMD_LOAD, 32'd5, 1'b1, 13'd0, 13'd0, 1'b0, 13'd0, STATUS_OK},
      '{CMD_QUERY, 32'h0, 1'b0, 13'd1, 13'd2, 1'b1, 13'd2, STATUS_OK},
      '{CMD_QUERY, 32'h0, 1'b0, 13'd1, 13'd3, 1'b1, 13'd0, STATUS_ERR},
      '{CMD_LOAD, 32'd9, 1'b0, 13'd0, 13'd0, 1'b0, 13'd0, STATUS_OK},
      '{CMD_LOAD, 32'd3, 1'b0, 13'd0, 13'd0, 1'b0, 13'd0, STATUS_OK},
      '{CMD_LOAD, 32'd9, 1'b1, 13'd0, 13'd0, 1'b0, 13'd0, STATUS_OK},
      '{CMD_QUERY, 32'h0, 1'b0, 13'd1, 13'd3, 1'b0, 13'd0, STATUS_OK}
   };

   sorted_range_mode_query dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_value(req_value), .req_final_load(req_final_load),
      .req_range_first(req_range_first), .req_range_last(req_range_last),
      .rsp_valid(rsp_valid), .rsp_frequency(rsp_frequency), .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------- predictor ----------------
   task automatic tree_write(input int pos, input int len);
      int i;
      i = MaxLen + pos - 1;
      run_tree[i] = len;
      i = i >> 1;
      while (i >= 1) begin
         run_tree[i] = (run_tree[2*i] > run_tree[2*i+1]) ? run_tree[2*i] : run_tree[2*i+1];
         i = i >> 1;
      end
   endtask

   function automatic int tree_range_max(input int first, input int last);
      int l;
      int r;
      int best;
      l = first - 1 + MaxLen;
      r = last + MaxLen;
      best = 0;
      while (l < r) begin
         if (l[0]) begin
            if (run_tree[l] > best) best = run_tree[l];
            l++;
         end
         if (r[0]) begin
            r--;
            if (run_tree[r] > best) best = run_tree[r];
         end
         l = l >> 1;
         r = r >> 1;
      end
      return best;
   endfunction

   task automatic seal_run();
      int lo;
      int hi;
      lo = run_open_lo;
      hi = arr_len;
      if (lo < 1 || lo > hi) return;
      for (int p = lo; p <= hi; p++) begin
         arr_run_lo[p-1] = lo;
         arr_run_hi[p-1] = hi;
         tree_write(p, hi - lo + 1);
      end
      run_open_lo = hi + 1;
   endtask

   task automatic apply_load(input logic [31:0] v, input logic fin);
      if (arr_len > 0 && run_open_lo > arr_len) begin
         arr_len = 0;
         run_open_lo = 1;
      end
      if (arr_len < MaxLen) begin
         if (arr_len == 0) begin
            run_open_lo = 1;
            run_open_value = v;
         end else if (v != run_open_value) begin
            seal_run();
            run_open_value = v;
         end
         arr_value[arr_len] = v;
         arr_len++;
      end
      if (fin) seal_run();
   endtask

   function automatic answer_type range_mode(input int s, input int e);
      answer_type ans;
      int pa;
      int pb;
      int pc;
      int best;
      ans.freq = '0;
      ans.status = STATUS_ERR;
      if (s < 1 || s > e || e > run_open_lo - 1 || e > MaxLen) return ans;
      ans.status = STATUS_OK;
      if (arr_value[s-1] == arr_value[e-1]) begin
         ans.freq = 13'(e - s + 1);
         return ans;
      end
      pa = 0;
      pb = 0;
      pc = 0;
      if (arr_run_lo[s-1] < s) begin
         pa = arr_run_hi[s-1] - s + 1;
         s = arr_run_hi[s-1] + 1;
      end
      if (arr_run_hi[e-1] > e) begin
         pc = e - arr_run_lo[e-1] + 1;
         e = arr_run_lo[e-1] - 1;
      end
      if (s >= 1 && s <= e && e <= MaxLen) pb = tree_range_max(s, e);
      best = pa;
      if (pb > best) best = pb;
      if (pc > best) best = pc;
      ans.freq = 13'(best);
      return ans;
   endfunction

   // ---------------- checker, predictor hookup, watchdog ----------------
   always @(posedge clock) begin
      answer_type want;
      answer_type ans;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected result freq=%0d status=%0d", $time, rsp_frequency,
                        rsp_status);
               fail_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_frequency !== want.freq) begin
                  $display("%0t: frequency expected %0d actual %0d", $time, want.freq,
                           rsp_frequency);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_status);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            if (req_cmd == CMD_LOAD) begin
               apply_load(req_value, req_final_load);
            end else begin
               ans = range_mode(int'(req_range_first), int'(req_range_last));
               if (row_typed) begin
                  ans.freq = row_freq;
                  ans.status = row_status;
               end
               pending_answers = {pending_answers, ans};
            end
         end
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ---------------- driver ----------------
   task automatic send(input logic cmd, input logic [31:0] v, input logic fin,
                       input logic [12:0] s, input logic [12:0] e, input bit typed,
                       input logic [12:0] f, input logic st);
      start <= 1'b1;
      req_cmd <= cmd;
      req_value <= v;
      req_final_load <= fin;
      req_range_first <= s;
      req_range_last <= e;
      row_typed <= typed;
      row_freq <= f;
      row_status <= st;
      do @(posedge clock); while (busy);
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 8);
      end
   endtask

   task automatic load(input logic [31:0] v, input logic fin);
      send(CMD_LOAD, v, fin, 13'($urandom), 13'($urandom), 1'b0, '0, STATUS_OK);
   endtask

   task automatic query(input int s, input int e);
      send(CMD_QUERY, $urandom, 1'($urandom), 13'(s), 13'(e), 1'b0, '0, STATUS_OK);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task automatic load_array(input int len, input int max_run, input bit ordered,
                             input bit fin);
      logic [31:0] v;
      int run_left;
      v = $urandom;
      run_left = $urandom_range(1, max_run);
      for (int k = 0; k < len; k++) begin
         if (run_left == 0) begin
            v = ordered ? v + $urandom_range(1, 1000) : 32'($urandom_range(0, 3));
            run_left = $urandom_range(1, max_run);
         end
         run_left--;
         load(v, fin && k == len - 1);
      end
   endtask

   task automatic random_queries(input int len, input int count);
      int s;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 6) == 0) begin
            query($urandom_range(0, 8191), $urandom_range(0, 8191));
         end else begin
            s = $urandom_range(1, len);
            query(s, $urandom_range(s, len));
         end
      end
   endtask

   initial begin
      int len;
      int sent;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_LOAD;
      req_value = '0;
      req_final_load = 1'b0;
      req_range_first = '0;
      req_range_last = '0;
      row_typed = 1'b0;
      row_freq = '0;
      row_status = STATUS_OK;
      fail_count = 0;
      idle_cycles = 0;
      burst_left = 4;
      arr_len = 0;
      run_open_lo = 1;
      run_open_value = '0;
      for (int i = 0; i < MaxLen; i++) begin
         arr_value[i] = '0;
         arr_run_lo[i] = 0;
         arr_run_hi[i] = 0;
      end
      for (int i = 0; i < 2 * MaxLen; i++) run_tree[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].fin, dir_rows[i].first,
              dir_rows[i].last, dir_rows[i].typed, dir_rows[i].freq, dir_rows[i].status);
      drain();

      // one long array, then queries over its whole span and just past its end
      load_array(FillLen, 8, 1'b1, 1'b1);
      query(1, FillLen);
      query(FillLen - 100, FillLen);
      query(FillLen, FillLen);
      query(1, FillLen + 1);
      random_queries(FillLen, 10);
      drain();

      sent = 0;
      while (sent < 400) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
         load_array(len, $urandom_range(1, len), $urandom_range(0, 7) != 0,
                    $urandom_range(0, 9) != 0);
         sent += len;
         len = $urandom_range(3, 15);
         random_queries(arr_len, len);
         sent += len;
         if ($urandom_range(0, 7) == 0) drain();
      end

      drain();
      repeat (64) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
